[src/self_calibrating_pulse_rate_counter_assert.svh]
// assertion macros used by the top-level asserting file
`ifndef SELF_CALIBRATING_PULSE_RATE_COUNTER_ASSERT_SVH
`define SELF_CALIBRATING_PULSE_RATE_COUNTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SCPRC_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("scprc check failed");

// next-cycle implication, checked outside reset
`define SCPRC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("scprc check failed");

`endif

[src/scprc_pkg.sv]
package scprc_pkg;

  // request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_STATS  = 1'b1;

  // (sum * 256000) / (2 * elapsed) == (sum * 128000) / elapsed
  localparam int unsigned SCALE_W = 17;
  localparam logic [SCALE_W-1:0] RATE_SCALE = 17'd128000;
  localparam int unsigned SUM_W = 33;
  localparam int unsigned PROD_W = SUM_W + SCALE_W;

  // per-sensor calibration and hysteresis state
  typedef struct packed {
    logic [7:0] peak_lvl;
    logic [7:0] floor_lvl;
    logic [7:0] thr;
    logic       lit;
  } sense_t;

  // one classified request handed from front to back
  typedef struct packed {
    logic              is_stats;
    logic              ezero;
    logic [31:0]       count_a;
    logic [31:0]       count_b;
    logic [SUM_W-1:0]  delta_sum;
    logic [31:0]       elapsed;
  } job_t;

  function automatic sense_t sense_step(input sense_t cur, input logic [7:0] v);
    sense_t     nxt;
    logic [8:0] acc;
    nxt = cur;
    if (v > cur.peak_lvl) begin
      nxt.peak_lvl = v;
      acc = {1'b0, v} + {1'b0, cur.floor_lvl};
      nxt.thr = acc[8:1];
    end else if ((v < cur.floor_lvl) || (cur.floor_lvl == 8'd0)) begin
      nxt.floor_lvl = v;
      acc = {1'b0, cur.peak_lvl} + {1'b0, v};
      nxt.thr = acc[8:1];
    end
    if (!cur.lit && (v > nxt.thr)) begin
      nxt.lit = 1'b1;
    end else if (cur.lit && (v < nxt.thr)) begin
      nxt.lit = 1'b0;
    end
    return nxt;
  endfunction

endpackage

[src/self_calibrating_pulse_rate_counter.sv]
// a sample request reaches the result side through the queue, the job register and
// the output register; a stats request through the queue, the scale multiply, the
// overflow check, the one-bit restoring division and the output register, the
// division skipped on zero elapsed time or overflow; the back end works on one request
// at a time and the front end keeps taking requests until the queue fills
// reset (rst, synchronous): calibration, counts, queue and result valid flag all clear
`include "self_calibrating_pulse_rate_counter_assert.svh"

module self_calibrating_pulse_rate_counter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [7:0]  sample_a,
  input  logic [7:0]  sample_b,
  input  logic [31:0] now_ms,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [31:0] count_a,
  output logic [31:0] count_b,
  output logic [31:0] rate_q8,
  output logic        rate_valid,
  output logic        elapsed_zero
);

  // a request is taken whenever push is high and the queue has room
  logic            accept;
  scprc_pkg::job_t front_job;
  scprc_pkg::job_t q_data;
  logic            q_full, q_empty, q_pop;

  assign accept = push && !q_full;
  assign full   = q_full;

  // front end: sensor calibration, hysteresis, counts, deltas since last stats
  scprc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req_type (req_type),
    .sample_a (sample_a),
    .sample_b (sample_b),
    .now_ms   (now_ms),
    .job      (front_job)
  );

  // short queue so the front keeps going while the divider works
  scprc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (front_job),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // back end: rate scaling, division, saturation and the result register
  scprc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .count_a      (count_a),
    .count_b      (count_b),
    .rate_q8      (rate_q8),
    .rate_valid   (rate_valid),
    .elapsed_zero (elapsed_zero)
  );

  // sample results carry no rate
  `SCPRC_ASSERT_NOW(a_sample_no_rate, clk, rst, !empty && !rate_valid, rate_q8 == '0 && !elapsed_zero)
  // zero elapsed time gives a zero rate on a stats result
  `SCPRC_ASSERT_NOW(a_ezero_rate, clk, rst, !empty && elapsed_zero, rate_valid && rate_q8 == 32'd0)
  // a taken request is always waiting in the queue on the next cycle
  `SCPRC_ASSERT_NEXT(a_push_queued, clk, rst, accept, !q_empty)

endmodule

[src/scprc_front.sv]
module scprc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               req_type,
  input  logic [7:0]         sample_a,
  input  logic [7:0]         sample_b,
  input  logic [31:0]        now_ms,
  output scprc_pkg::job_t    job
);

  scprc_pkg::sense_t sens_a, sens_b;
  scprc_pkg::sense_t sens_a_next, sens_b_next;
  logic [31:0] pulse_a, pulse_b;
  logic [31:0] pulse_a_next, pulse_b_next;
  logic [31:0] prior_a, prior_b, prior_time;
  logic [31:0] delta_a, delta_b, elapsed;

  assign sens_a_next = scprc_pkg::sense_step(sens_a, sample_a);
  assign sens_b_next = scprc_pkg::sense_step(sens_b, sample_b);
  // count on dark-to-lit only
  assign pulse_a_next = pulse_a + {31'd0, (!sens_a.lit && sens_a_next.lit)};
  assign pulse_b_next = pulse_b + {31'd0, (!sens_b.lit && sens_b_next.lit)};

  assign delta_a = pulse_a - prior_a;
  assign delta_b = pulse_b - prior_b;
  assign elapsed = now_ms - prior_time;

  always_comb begin
    job.is_stats  = (req_type == scprc_pkg::REQ_STATS);
    job.ezero     = job.is_stats && (elapsed == 32'd0);
    job.elapsed   = elapsed;
    job.delta_sum = {1'b0, delta_a} + {1'b0, delta_b};
    if (job.is_stats) begin
      job.count_a = pulse_a;
      job.count_b = pulse_b;
    end else begin
      job.count_a = pulse_a_next;
      job.count_b = pulse_b_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sens_a     <= '0;
      sens_b     <= '0;
      pulse_a    <= '0;
      pulse_b    <= '0;
      prior_a    <= '0;
      prior_b    <= '0;
      prior_time <= '0;
    end else if (accept) begin
      if (req_type == scprc_pkg::REQ_STATS) begin
        prior_a    <= pulse_a;
        prior_b    <= pulse_b;
        prior_time <= now_ms;
      end else begin
        sens_a  <= sens_a_next;
        sens_b  <= sens_b_next;
        pulse_a <= pulse_a_next;
        pulse_b <= pulse_b_next;
      end
    end
  end

endmodule

[src/scprc_queue.sv]
module scprc_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  scprc_pkg::job_t wr_data,
  input  logic            rd_en,
  output scprc_pkg::job_t rd_data,
  output logic            q_full,
  output logic            q_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  scprc_pkg::job_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;

  assign q_full  = (fill == FULL_CNT);
  assign q_empty = (fill == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[src/scprc_back.sv]
module scprc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  scprc_pkg::job_t q_data,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output logic [31:0]     count_a,
  output logic [31:0]     count_b,
  output logic [31:0]     rate_q8,
  output logic            rate_valid,
  output logic            elapsed_zero
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CHK  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;
  scprc_pkg::job_t job;
  logic [scprc_pkg::PROD_W-1:0] prod;
  logic [31:0] rem, quot;
  logic [4:0]  bit_cnt;
  logic        out_valid;
  logic        out_free;
  logic        out_load;
  logic [32:0] r2;
  logic        fits;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign out_load = (state == S_OUT) && out_free;
  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign r2       = {rem, quot[31]};
  assign fits     = (r2 >= {1'b0, job.elapsed});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop && out_valid) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            job  <= q_data;
            quot <= '0;
            prod <= q_data.delta_sum * scprc_pkg::RATE_SCALE;
            if (q_data.is_stats && !q_data.ezero) begin
              state <= S_CHK;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_CHK: begin
          // quotient overflows 32 bits when the upper part already holds the divisor
          if ({14'd0, prod[scprc_pkg::PROD_W-1:32]} >= job.elapsed) begin
            quot  <= '1;
            state <= S_OUT;
          end else begin
            rem     <= {14'd0, prod[scprc_pkg::PROD_W-1:32]};
            quot    <= prod[31:0];
            bit_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring step, quotient bits shift in behind the dividend bits
          if (fits) begin
            rem <= 32'(r2 - {1'b0, job.elapsed});
          end else begin
            rem <= r2[31:0];
          end
          quot    <= {quot[30:0], fits};
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == 5'd31) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            count_a      <= job.count_a;
            count_b      <= job.count_b;
            rate_q8      <= quot;
            rate_valid   <= job.is_stats;
            elapsed_zero <= job.ezero;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
